// ===== hw/rtl/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// shared widths, constants and types of the filled circle span generator
// ----------------------------------------------------------------------------
package fcsg_pkg;

  localparam int CoordW        = 15;
  localparam int RadW          = 7;
  localparam int OutW          = 16;
  localparam int ErrW          = 10;
  localparam int MaxRadiusDef  = 88;
  localparam int ResultCap     = 64;
  localparam int CntW          = 7;
  localparam int QueueDepth    = 2;
  localparam int QPtrW         = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW         = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [RadW-1:0]          rad;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BACK_IDLE = 2'b01,
    BACK_RUN  = 2'b10
  } back_state_t;

endpackage

// ===== hw/rtl/filled_circle_span_generator_top.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator_top
// fill-circle command in; while a circle runs, four horizontal spans per cycle
//
//   channel  handshake          payload
//   input    start / busy       in_center_x, in_center_y, in_radius
//   output   out_valid strobe   eight span coordinates, out_last_of_circle
//
// a circle of radius r yields about 0.71*r + 1 transactions (at most 64), one
// per cycle from the iteration engine in the back part; a command passes the
// hold slot, the queue, the iteration registers and the output registers
// the front holds one command and the queue two more, so commands can be taken
// while a circle is still running; busy is high while the front's slot is full
// reset is synchronous and clears control state only
// results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module filled_circle_span_generator_top #(
  parameter int MAX_RADIUS = fcsg_pkg::MaxRadiusDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fcsg_pkg::CoordW-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CoordW-1:0] in_center_y,
  input  logic [fcsg_pkg::RadW-1:0]          in_radius,
  output logic                               out_valid,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_x_left,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_x_right,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_row_below,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_row_above,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_x_left,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_x_right,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_row_below,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_row_above,
  output logic                               out_last_of_circle
);

  fcsg_pkg::queue_stat_t q_stat;
  fcsg_pkg::cmd_t        push_cmd;
  fcsg_pkg::cmd_t        pop_cmd;
  logic                  push;
  logic                  pop;

  fcsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  fcsg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  fcsg_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_stat               (q_stat),
    .pop_cmd              (pop_cmd),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_wide_x_left      (out_wide_x_left),
    .out_wide_x_right     (out_wide_x_right),
    .out_wide_row_below   (out_wide_row_below),
    .out_wide_row_above   (out_wide_row_above),
    .out_narrow_x_left    (out_narrow_x_left),
    .out_narrow_x_right   (out_narrow_x_right),
    .out_narrow_row_below (out_narrow_row_below),
    .out_narrow_row_above (out_narrow_row_above),
    .out_last_of_circle   (out_last_of_circle)
  );

endmodule

// ===== hw/rtl/fcsg_front.sv =====
// ----------------------------------------------------------------------------
// fcsg_front
// accepts a circle command, clamps the radius and hands it to the queue
// ----------------------------------------------------------------------------
module fcsg_front #(
  parameter int MAX_RADIUS = fcsg_pkg::MaxRadiusDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fcsg_pkg::CoordW-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CoordW-1:0] in_center_y,
  input  logic [fcsg_pkg::RadW-1:0]          in_radius,
  input  fcsg_pkg::queue_stat_t              q_stat,
  output logic                               push,
  output fcsg_pkg::cmd_t                     push_cmd
);

  localparam logic [fcsg_pkg::RadW-1:0] RadMax = fcsg_pkg::RadW'(MAX_RADIUS);

  fcsg_pkg::cmd_t hold_r;
  logic           hold_vld_r;
  logic           accept;
  logic [fcsg_pkg::RadW-1:0] rad_clamped;

  assign busy        = hold_vld_r;
  assign accept      = start && !hold_vld_r;
  assign push        = hold_vld_r && !q_stat.full;
  assign push_cmd    = hold_r;
  assign rad_clamped = (in_radius > RadMax) ? RadMax : in_radius;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (accept) begin
      hold_vld_r <= 1'b1;
    end else if (push) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.cx  <= in_center_x;
      hold_r.cy  <= in_center_y;
      hold_r.rad <= rad_clamped;
    end
  end

endmodule

// ===== hw/rtl/fcsg_queue.sv =====
// ----------------------------------------------------------------------------
// fcsg_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module fcsg_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fcsg_pkg::cmd_t        push_cmd,
  input  logic                  pop,
  output fcsg_pkg::cmd_t        pop_cmd,
  output fcsg_pkg::queue_stat_t q_stat
);

  fcsg_pkg::cmd_t                mem_r [fcsg_pkg::QueueDepth];
  logic [fcsg_pkg::QPtrW-1:0]    wr_ptr_r;
  logic [fcsg_pkg::QPtrW-1:0]    rd_ptr_r;
  logic [fcsg_pkg::QCntW-1:0]    cnt_r;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [fcsg_pkg::QCntW-1:0] CntFull = fcsg_pkg::QCntW'(fcsg_pkg::QueueDepth);
  localparam logic [fcsg_pkg::QPtrW-1:0] PtrLast =
    fcsg_pkg::QPtrW'(fcsg_pkg::QueueDepth - 1);

  assign q_stat.full  = (cnt_r == CntFull);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/fcsg_back.sv =====
// ----------------------------------------------------------------------------
// fcsg_back
// midpoint circle iteration, one span set per cycle while a circle runs
// ----------------------------------------------------------------------------
module fcsg_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fcsg_pkg::queue_stat_t              q_stat,
  input  fcsg_pkg::cmd_t                     pop_cmd,
  output logic                               pop,
  output logic                               out_valid,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_x_left,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_x_right,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_row_below,
  output logic signed [fcsg_pkg::OutW-1:0]   out_wide_row_above,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_x_left,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_x_right,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_row_below,
  output logic signed [fcsg_pkg::OutW-1:0]   out_narrow_row_above,
  output logic                               out_last_of_circle
);

  localparam int RadW = fcsg_pkg::RadW;
  localparam int ErrW = fcsg_pkg::ErrW;
  localparam int OutW = fcsg_pkg::OutW;
  localparam int CntW = fcsg_pkg::CntW;
  localparam logic [CntW-1:0] CntCap = CntW'(fcsg_pkg::ResultCap);

  fcsg_pkg::back_state_t state_r, state_nxt;

  logic signed [fcsg_pkg::CoordW-1:0] cx_r, cy_r;
  logic [RadW-1:0]        x_r, x_nxt;
  logic [RadW-1:0]        y_r, y_nxt;
  logic signed [ErrW-1:0] err_r, err_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;

  logic                   dec;
  logic signed [RadW:0]   x_step_s;
  logic signed [ErrW-1:0] xs, ys, inc_lo, inc_hi;
  logic                   last;
  logic signed [OutW-1:0] cx16, cy16, x16, y16;

  logic                   valid_r;
  logic signed [OutW-1:0] wxl_r, wxr_r, wrb_r, wra_r, nxl_r, nxr_r, nrb_r, nra_r;
  logic                   last_r;

  assign pop = (state_r == fcsg_pkg::BACK_IDLE) && !q_stat.empty;

  // next iteration values
  always_comb begin
    dec      = !err_r[ErrW-1];
    y_nxt    = y_r + 1'b1;
    x_step_s = $signed({1'b0, x_r}) - $signed({{RadW{1'b0}}, dec});
    x_nxt    = x_step_s[RadW-1:0];
    ys       = $signed({{(ErrW-RadW){1'b0}}, y_nxt});
    xs       = $signed({{(ErrW-RadW){1'b0}}, x_nxt});
    inc_lo   = (ys <<< 1) + ErrW'(1);
    inc_hi   = ((ys - xs) <<< 1) + ErrW'(2);
    err_nxt  = dec ? (err_r + inc_hi) : (err_r + inc_lo);
    cnt_nxt  = cnt_r + 1'b1;
    last     = (x_step_s < $signed({1'b0, y_nxt})) || (cnt_nxt >= CntCap);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcsg_pkg::BACK_IDLE: begin
        if (pop) state_nxt = fcsg_pkg::BACK_RUN;
      end
      fcsg_pkg::BACK_RUN: begin
        if (last) state_nxt = fcsg_pkg::BACK_IDLE;
      end
      default: state_nxt = fcsg_pkg::BACK_IDLE;
    endcase
  end

  assign cx16 = OutW'(cx_r);
  assign cy16 = OutW'(cy_r);
  assign x16  = $signed({{(OutW-RadW){1'b0}}, x_r});
  assign y16  = $signed({{(OutW-RadW){1'b0}}, y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcsg_pkg::BACK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == fcsg_pkg::BACK_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx_r  <= pop_cmd.cx;
      cy_r  <= pop_cmd.cy;
      x_r   <= pop_cmd.rad;
      y_r   <= '0;
      err_r <= ErrW'(1) - $signed({{(ErrW-RadW){1'b0}}, pop_cmd.rad});
      cnt_r <= '0;
    end else if (state_r == fcsg_pkg::BACK_RUN) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fcsg_pkg::BACK_RUN) begin
      wxl_r  <= cx16 - x16;
      wxr_r  <= cx16 + x16;
      wrb_r  <= cy16 + y16;
      wra_r  <= cy16 - y16;
      nxl_r  <= cx16 - y16;
      nxr_r  <= cx16 + y16;
      nrb_r  <= cy16 + x16;
      nra_r  <= cy16 - x16;
      last_r <= last;
    end
  end

  assign out_valid            = valid_r;
  assign out_wide_x_left      = wxl_r;
  assign out_wide_x_right     = wxr_r;
  assign out_wide_row_below   = wrb_r;
  assign out_wide_row_above   = wra_r;
  assign out_narrow_x_left    = nxl_r;
  assign out_narrow_x_right   = nxr_r;
  assign out_narrow_row_below = nrb_r;
  assign out_narrow_row_above = nra_r;
  assign out_last_of_circle   = last_r;

endmodule

// ===== hw/rtl/fcsg_checker.sv =====
// ----------------------------------------------------------------------------
// fcsg_checker
// port-level checks on the span output, bound to the top level
// ----------------------------------------------------------------------------
module fcsg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic signed [fcsg_pkg::OutW-1:0] out_wide_x_left,
  input logic signed [fcsg_pkg::OutW-1:0] out_wide_x_right,
  input logic signed [fcsg_pkg::OutW-1:0] out_wide_row_below,
  input logic signed [fcsg_pkg::OutW-1:0] out_wide_row_above,
  input logic signed [fcsg_pkg::OutW-1:0] out_narrow_x_left,
  input logic signed [fcsg_pkg::OutW-1:0] out_narrow_x_right,
  input logic signed [fcsg_pkg::OutW-1:0] out_narrow_row_below,
  input logic signed [fcsg_pkg::OutW-1:0] out_narrow_row_above,
  input logic                             out_last_of_circle
);

  logic [fcsg_pkg::OutW-1:0] wide_w, wide_h, narrow_w, narrow_h;

  assign wide_w   = out_wide_x_right - out_wide_x_left;
  assign narrow_h = out_narrow_row_below - out_narrow_row_above;
  assign narrow_w = out_narrow_x_right - out_narrow_x_left;
  assign wide_h   = out_wide_row_below - out_wide_row_above;

  // no transaction in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("transaction right after reset");

  // a circle runs without gaps until its last transaction
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_circle |=> out_valid)
    else $error("gap inside a circle");

  // wide span width matches narrow row distance, both twice the x offset
  a_x_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> wide_w == narrow_h)
    else $error("x offset mismatch");

  // narrow span width matches wide row distance, both twice the y offset
  a_y_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> narrow_w == wide_h)
    else $error("y offset mismatch");

  // y offset steps by one between iterations of a circle
  a_y_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_circle |=>
      out_wide_row_below == $past(out_wide_row_below) + 16'sd1)
    else $error("y offset did not step by one");

endmodule

bind filled_circle_span_generator_top fcsg_checker u_fcsg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_wide_x_left      (out_wide_x_left),
  .out_wide_x_right     (out_wide_x_right),
  .out_wide_row_below   (out_wide_row_below),
  .out_wide_row_above   (out_wide_row_above),
  .out_narrow_x_left    (out_narrow_x_left),
  .out_narrow_x_right   (out_narrow_x_right),
  .out_narrow_row_below (out_narrow_row_below),
  .out_narrow_row_above (out_narrow_row_above),
  .out_last_of_circle   (out_last_of_circle)
);
